/* rtl/lsnb_pkg.sv */
// lsnb_pkg: shared constants, command/status structs and state types for the
// LFO sine/noise blend core. No dependencies.
package lsnb_pkg;

    // Q4.28 phase constants and Q2.30 polynomial coefficients
    localparam logic [31:0] PI_Q     = 32'd843314857;
    localparam logic [30:0] TWO_PI_Q = 31'd1686629713;
    localparam logic [30:0] K1_Q     = 31'd1367130552;
    localparam logic [28:0] K2_Q     = 29'd435171170;
    localparam logic [27:0] K3_Q     = 28'd241591910;

    localparam logic [27:0] WARP_RESET = 28'd384000;

    // shared multiplier operand width
    localparam int MW = 36;

    // input operation codes
    localparam logic OPN_TICK    = 1'b0;
    localparam logic OPN_RESTART = 1'b1;

    typedef enum logic [2:0] {
        REG_RATE  = 3'd0,
        REG_STEP  = 3'd1,
        REG_WARP  = 3'd2,
        REG_SHAPE = 3'd3,
        REG_GAIN  = 3'd4
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_RESTART, OP_MUL_STEP, OP_ADD, OP_WRAP,
        OP_K1, OP_PSQ, OP_K2, OP_Y, OP_YSQ, OP_K3, OP_S,
        OP_N1, OP_N2, OP_NSUM, OP_DINIT, OP_DIV, OP_FSAT,
        OP_MIXLO, OP_MIXHI, OP_MIXSUM, OP_M, OP_GLO, OP_GHI, OP_GSUM, OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_STEP, ST_ADD, ST_WRAP, ST_K1, ST_PSQ, ST_K2, ST_Y,
        ST_YSQ, ST_K3, ST_S, ST_N1, ST_N2, ST_NSUM, ST_DINIT, ST_DIV,
        ST_FSAT, ST_MIXLO, ST_MIXHI, ST_MIXSUM, ST_M, ST_GLO, ST_GHI,
        ST_GSUM, ST_OUT
    } ctrl_st_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic wrap_done;
        logic den_zero;
        logic div_last;
        logic out_hold;
    } dp_status_t;

endpackage

/* rtl/lsnb_ctrl.sv */
// lsnb_ctrl: sequencer for the LFO blend core; steps the datapath one
// operation per cycle, holding while the output is stalled. Depends on lsnb_pkg.
module lsnb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  operation,
    output logic                  in_stall,
    input  lsnb_pkg::dp_status_t  status,
    output lsnb_pkg::dp_cmd_t     cmd
);

    lsnb_pkg::ctrl_st_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsnb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = lsnb_pkg::OP_IDLE;
        in_stall   = (state_reg != lsnb_pkg::ST_IDLE);
        unique case (state_reg)
            lsnb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == lsnb_pkg::OPN_RESTART)
                    begin
                        cmd.op = lsnb_pkg::OP_RESTART;
                    end
                    else
                    begin
                        cmd.op     = lsnb_pkg::OP_LOAD;
                        state_next = lsnb_pkg::ST_STEP;
                    end
                end
            end
            lsnb_pkg::ST_STEP:
            begin
                cmd.op = lsnb_pkg::OP_MUL_STEP; state_next = lsnb_pkg::ST_ADD;
            end
            lsnb_pkg::ST_ADD:
            begin
                cmd.op = lsnb_pkg::OP_ADD; state_next = lsnb_pkg::ST_WRAP;
            end
            lsnb_pkg::ST_WRAP:
            begin
                // one two-pi subtraction a cycle until the phase is in range
                cmd.op = lsnb_pkg::OP_WRAP;
                if (status.wrap_done)
                begin
                    state_next = lsnb_pkg::ST_K1;
                end
            end
            lsnb_pkg::ST_K1:
            begin
                cmd.op = lsnb_pkg::OP_K1; state_next = lsnb_pkg::ST_PSQ;
            end
            lsnb_pkg::ST_PSQ:
            begin
                cmd.op = lsnb_pkg::OP_PSQ; state_next = lsnb_pkg::ST_K2;
            end
            lsnb_pkg::ST_K2:
            begin
                cmd.op = lsnb_pkg::OP_K2; state_next = lsnb_pkg::ST_Y;
            end
            lsnb_pkg::ST_Y:
            begin
                cmd.op = lsnb_pkg::OP_Y; state_next = lsnb_pkg::ST_YSQ;
            end
            lsnb_pkg::ST_YSQ:
            begin
                cmd.op = lsnb_pkg::OP_YSQ; state_next = lsnb_pkg::ST_K3;
            end
            lsnb_pkg::ST_K3:
            begin
                cmd.op = lsnb_pkg::OP_K3; state_next = lsnb_pkg::ST_S;
            end
            lsnb_pkg::ST_S:
            begin
                cmd.op = lsnb_pkg::OP_S; state_next = lsnb_pkg::ST_N1;
            end
            lsnb_pkg::ST_N1:
            begin
                cmd.op = lsnb_pkg::OP_N1; state_next = lsnb_pkg::ST_N2;
            end
            lsnb_pkg::ST_N2:
            begin
                cmd.op = lsnb_pkg::OP_N2; state_next = lsnb_pkg::ST_NSUM;
            end
            lsnb_pkg::ST_NSUM:
            begin
                cmd.op = lsnb_pkg::OP_NSUM; state_next = lsnb_pkg::ST_DINIT;
            end
            lsnb_pkg::ST_DINIT:
            begin
                cmd.op     = lsnb_pkg::OP_DINIT;
                state_next = status.den_zero ? lsnb_pkg::ST_FSAT : lsnb_pkg::ST_DIV;
            end
            lsnb_pkg::ST_DIV:
            begin
                cmd.op = lsnb_pkg::OP_DIV;
                if (status.div_last)
                begin
                    state_next = lsnb_pkg::ST_FSAT;
                end
            end
            lsnb_pkg::ST_FSAT:
            begin
                cmd.op = lsnb_pkg::OP_FSAT; state_next = lsnb_pkg::ST_MIXLO;
            end
            lsnb_pkg::ST_MIXLO:
            begin
                cmd.op = lsnb_pkg::OP_MIXLO; state_next = lsnb_pkg::ST_MIXHI;
            end
            lsnb_pkg::ST_MIXHI:
            begin
                cmd.op = lsnb_pkg::OP_MIXHI; state_next = lsnb_pkg::ST_MIXSUM;
            end
            lsnb_pkg::ST_MIXSUM:
            begin
                cmd.op = lsnb_pkg::OP_MIXSUM; state_next = lsnb_pkg::ST_M;
            end
            lsnb_pkg::ST_M:
            begin
                cmd.op = lsnb_pkg::OP_M; state_next = lsnb_pkg::ST_GLO;
            end
            lsnb_pkg::ST_GLO:
            begin
                cmd.op = lsnb_pkg::OP_GLO; state_next = lsnb_pkg::ST_GHI;
            end
            lsnb_pkg::ST_GHI:
            begin
                cmd.op = lsnb_pkg::OP_GHI; state_next = lsnb_pkg::ST_GSUM;
            end
            lsnb_pkg::ST_GSUM:
            begin
                cmd.op = lsnb_pkg::OP_GSUM; state_next = lsnb_pkg::ST_OUT;
            end
            lsnb_pkg::ST_OUT:
            begin
                // hold until the output register is free
                if (!status.out_hold)
                begin
                    cmd.op     = lsnb_pkg::OP_OUT;
                    state_next = lsnb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsnb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lsnb_datapath.sv */
// lsnb_datapath: configuration registers, oscillator/filter state, shared
// 36x36 multiplier, radix-2 divider and output register. Depends on lsnb_pkg.
module lsnb_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lsnb_pkg::dp_cmd_t     cmd,
    output lsnb_pkg::dp_status_t  status,
    input  logic signed [23:0]    noise_sample,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [23:0]    lfo_value
);

    localparam logic signed [37:0] PI_38 = 38'sd843314857;

    // configuration
    logic [23:0]        rate_reg,  rate_next;
    logic [31:0]        spz_reg,   spz_next;
    logic [27:0]        warp_reg,  warp_next;
    logic [16:0]        shape_reg, shape_next;
    logic signed [19:0] gain_reg,  gain_next;

    // architectural state
    logic signed [31:0] phase_reg, phase_next;
    logic signed [31:0] filt_reg,  filt_next;
    logic signed [23:0] prev_reg,  prev_next;
    logic               ovalid_reg, ovalid_next;

    // working registers
    logic signed [23:0] noise_reg, noise_next;
    logic signed [37:0] p_reg,     p_next;
    logic signed [35:0] t_reg,     t_next;
    logic signed [35:0] y_reg,     y_next;
    logic signed [35:0] s_reg,     s_next;
    logic [18:0]        a_reg,     a_next;
    logic signed [63:0] acc_reg,   acc_next;
    logic [28:0]        den_reg,   den_next;
    logic [63:0]        dq_reg,    dq_next;
    logic [28:0]        rem_reg,   rem_next;
    logic [6:0]         cnt_reg,   cnt_next;
    logic               qneg_reg,  qneg_next;
    logic signed [31:0] f_reg,     f_next;
    logic signed [43:0] wr_reg,    wr_next;
    logic signed [71:0] prod_reg,  prod_next;
    logic signed [23:0] out_reg,   out_next;

    logic signed [lsnb_pkg::MW-1:0] mop_a, mop_b;
    logic signed [32:0] ph_ext, ph_abs;
    logic signed [35:0] y_abs, q_val, r_val, diff_val;
    logic signed [43:0] f_sh, d_val;
    logic signed [39:0] o_val;
    logic [29:0]        trial;
    logic signed [31:0] f_sat;

    always_comb
    begin
        ph_ext   = {phase_reg[31], phase_reg};
        ph_abs   = ph_ext[32] ? -ph_ext : ph_ext;
        y_abs    = y_reg[35] ? -y_reg : y_reg;
        q_val    = $signed(prod_reg[63:28]);
        r_val    = $signed(prod_reg[63:28]) - y_reg;
        diff_val = {{12{prev_reg[23]}}, prev_reg} + {{12{noise_reg[23]}}, noise_reg}
                 - {{4{filt_reg[31]}}, filt_reg};
        f_sh     = {{4{f_reg[31]}}, f_reg, 8'd0};
        d_val    = {{8{s_reg[35]}}, s_reg} - f_sh;
        o_val    = $signed(acc_reg[63:24]);
        trial    = {rem_reg, dq_reg[63]};
        // signed quotient, truncated toward zero, clipped to 32 bits
        if (qneg_reg)
        begin
            f_sat = (dq_reg > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(dq_reg[31:0]);
        end
        else
        begin
            f_sat = (dq_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq_reg[31:0]);
        end
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        mop_a = '0;
        mop_b = '0;
        unique case (cmd.op)
            lsnb_pkg::OP_MUL_STEP:
            begin
                mop_a = {4'd0, spz_reg};
                mop_b = {12'd0, rate_reg};
            end
            lsnb_pkg::OP_K1:
            begin
                mop_a = {5'd0, lsnb_pkg::K1_Q};
                mop_b = {{4{p_reg[31]}}, p_reg[31:0]};
            end
            lsnb_pkg::OP_PSQ:
            begin
                mop_a = {{4{phase_reg[31]}}, phase_reg};
                mop_b = {{3{ph_abs[32]}}, ph_abs};
            end
            lsnb_pkg::OP_K2:
            begin
                mop_a = {7'd0, lsnb_pkg::K2_Q};
                mop_b = q_val;
            end
            lsnb_pkg::OP_YSQ:
            begin
                mop_a = y_reg;
                mop_b = y_abs;
            end
            lsnb_pkg::OP_K3:
            begin
                mop_a = {8'd0, lsnb_pkg::K3_Q};
                mop_b = r_val;
            end
            lsnb_pkg::OP_S:
            begin
                mop_a = {5'd0, lsnb_pkg::TWO_PI_Q};
                mop_b = {12'd0, rate_reg};
            end
            lsnb_pkg::OP_N1:
            begin
                mop_a = {17'd0, prod_reg[54:36]};
                mop_b = diff_val;
            end
            lsnb_pkg::OP_N2:
            begin
                mop_a = {8'd0, warp_reg};
                mop_b = {{4{filt_reg[31]}}, filt_reg};
            end
            lsnb_pkg::OP_MIXLO:
            begin
                mop_a = {18'd0, d_val[17:0]};
                mop_b = {19'd0, shape_reg};
            end
            lsnb_pkg::OP_MIXHI:
            begin
                mop_a = {{10{wr_reg[43]}}, wr_reg[43:18]};
                mop_b = {19'd0, shape_reg};
            end
            lsnb_pkg::OP_GLO:
            begin
                mop_a = {18'd0, wr_reg[17:0]};
                mop_b = {{16{gain_reg[19]}}, gain_reg};
            end
            lsnb_pkg::OP_GHI:
            begin
                mop_a = {{10{wr_reg[43]}}, wr_reg[43:18]};
                mop_b = {{16{gain_reg[19]}}, gain_reg};
            end
            default:
            begin
                mop_a = '0;
                mop_b = '0;
            end
        endcase
    end

    always_comb
    begin
        rate_next   = rate_reg;
        spz_next    = spz_reg;
        warp_next   = warp_reg;
        shape_next  = shape_reg;
        gain_next   = gain_reg;
        phase_next  = phase_reg;
        filt_next   = filt_reg;
        prev_next   = prev_reg;
        noise_next  = noise_reg;
        p_next      = p_reg;
        t_next      = t_reg;
        y_next      = y_reg;
        s_next      = s_reg;
        a_next      = a_reg;
        acc_next    = acc_reg;
        den_next    = den_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        qneg_next   = qneg_reg;
        f_next      = f_reg;
        wr_next     = wr_reg;
        out_next    = out_reg;
        prod_next   = mop_a * mop_b;
        ovalid_next = ovalid_reg && out_stall;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                lsnb_pkg::REG_RATE:  rate_next  = cfg_data[23:0];
                lsnb_pkg::REG_STEP:  spz_next   = cfg_data;
                lsnb_pkg::REG_WARP:  warp_next  = cfg_data[27:0];
                lsnb_pkg::REG_SHAPE: shape_next = cfg_data[16:0];
                lsnb_pkg::REG_GAIN:  gain_next  = $signed(cfg_data[19:0]);
                default: ;
            endcase
        end

        unique case (cmd.op)
            lsnb_pkg::OP_LOAD:    noise_next = noise_sample;
            lsnb_pkg::OP_RESTART:
            begin
                phase_next = '0;
                filt_next  = '0;
                prev_next  = '0;
            end
            lsnb_pkg::OP_ADD:
                p_next = {{6{phase_reg[31]}}, phase_reg} + $signed({2'd0, prod_reg[55:20]});
            lsnb_pkg::OP_WRAP:
            begin
                if (p_reg > PI_38)
                begin
                    p_next = p_reg - $signed({7'd0, lsnb_pkg::TWO_PI_Q});
                end
            end
            lsnb_pkg::OP_K1:      phase_next = p_reg[31:0];
            lsnb_pkg::OP_PSQ:     t_next = $signed(prod_reg[65:30]);
            lsnb_pkg::OP_Y:       y_next = t_reg - $signed(prod_reg[65:30]);
            lsnb_pkg::OP_S:       s_next = $signed(prod_reg[65:30]) + y_reg;
            lsnb_pkg::OP_N1:      a_next = prod_reg[54:36];
            lsnb_pkg::OP_N2:      acc_next = prod_reg[63:0];
            lsnb_pkg::OP_NSUM:
            begin
                acc_next = acc_reg + $signed(prod_reg[63:0]);
                den_next = {1'b0, warp_reg} + {10'd0, a_reg};
            end
            lsnb_pkg::OP_DINIT:
            begin
                qneg_next = acc_reg[63];
                dq_next   = acc_reg[63] ? -acc_reg : acc_reg;
                rem_next  = '0;
                cnt_next  = 7'd64;
            end
            lsnb_pkg::OP_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 29'(trial - {1'b0, den_reg});
                    dq_next  = {dq_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[28:0];
                    dq_next  = {dq_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
            end
            lsnb_pkg::OP_FSAT:
            begin
                // zero denominator keeps the previous filter output
                f_next    = (den_reg == '0) ? filt_reg : f_sat;
                filt_next = (den_reg == '0) ? filt_reg : f_sat;
                prev_next = noise_reg;
            end
            lsnb_pkg::OP_MIXLO:   wr_next = d_val;
            lsnb_pkg::OP_MIXHI:   acc_next = prod_reg[63:0];
            lsnb_pkg::OP_MIXSUM:  acc_next = acc_reg + ($signed(prod_reg[63:0]) <<< 18);
            lsnb_pkg::OP_M:       wr_next = $signed(acc_reg[59:16]) + f_sh;
            lsnb_pkg::OP_GHI:     acc_next = prod_reg[63:0];
            lsnb_pkg::OP_GSUM:    acc_next = acc_reg + ($signed(prod_reg[63:0]) <<< 18);
            lsnb_pkg::OP_OUT:
            begin
                if (o_val > 40'sd8388607)
                begin
                    out_next = 24'sh7FFFFF;
                end
                else if (o_val < -40'sd8388608)
                begin
                    out_next = 24'sh800000;
                end
                else
                begin
                    out_next = o_val[23:0];
                end
                ovalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= '0;
            spz_reg    <= '0;
            warp_reg   <= lsnb_pkg::WARP_RESET;
            shape_reg  <= '0;
            gain_reg   <= '0;
            phase_reg  <= '0;
            filt_reg   <= '0;
            prev_reg   <= '0;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            rate_reg   <= rate_next;
            spz_reg    <= spz_next;
            warp_reg   <= warp_next;
            shape_reg  <= shape_next;
            gain_reg   <= gain_next;
            phase_reg  <= phase_next;
            filt_reg   <= filt_next;
            prev_reg   <= prev_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        noise_reg <= noise_next;
        p_reg     <= p_next;
        t_reg     <= t_next;
        y_reg     <= y_next;
        s_reg     <= s_next;
        a_reg     <= a_next;
        acc_reg   <= acc_next;
        den_reg   <= den_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        qneg_reg  <= qneg_next;
        f_reg     <= f_next;
        wr_reg    <= wr_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

    assign status.wrap_done = !(p_reg > PI_38);
    assign status.den_zero  = (den_reg == '0);
    assign status.div_last  = (cnt_reg == 7'd1);
    assign status.out_hold  = ovalid_reg && out_stall;

    assign out_valid = ovalid_reg;
    assign lfo_value = out_reg;

endmodule

/* rtl/lfo_sine_noise_blend_core.sv */
// Top level of the LFO sine/noise blend core: sequencer plus datapath.
// Depends on lsnb_pkg, lsnb_ctrl, lsnb_datapath.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | operation, noise_sample
//  out     | output    | out_valid/out_stall| lfo_value
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick item makes W (1..42) wrap passes and D = 64 divider steps (0 when the
// filter denominator is zero); the radix-2 divider sets it.
// A restart item leaves the sequencer idle. One item is in work at a time.
// Reset is asynchronous and clears state and configuration to defaults.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only its own write-back waits on out_stall.
module lfo_sine_noise_blend_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [23:0] noise_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] lfo_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    lsnb_pkg::dp_cmd_t    cmd;
    lsnb_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    lsnb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lsnb_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .noise_sample (noise_sample),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .lfo_value    (lfo_value)
    );

endmodule

/* rtl/lsnb_checker.sv */
// lsnb_checker: port-level assertions for the LFO blend core, bound to the
// top level. Depends on lfo_sine_noise_blend_core and lsnb_pkg.
module lsnb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               operation,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [23:0] lfo_value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lfo_value))
        else $error("stalled result changed");

    // a tick item keeps the block busy for at least the next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == lsnb_pkg::OPN_TICK |=> in_stall)
        else $error("tick item not sequenced");

    // restart completes at once
    a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == lsnb_pkg::OPN_RESTART |=> !in_stall)
        else $error("restart left block busy");

    // a new result only appears at the end of a tick's work
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

endmodule

bind lfo_sine_noise_blend_core lsnb_checker u_lsnb_checker (.*);

/* tb/lsnb_checker.sv */
// lsnb_tb_checker: watches the cfg, in and out channels of the LFO blend core,
// predicts each lfo_value and compares it with the core's output. Uses lsnb_pkg.
`timescale 1ns / 100ps
module lsnb_tb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               operation,
    input  logic signed [23:0] noise_sample,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [23:0] lfo_value,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    // configuration copy
    logic [23:0]        rate_q;
    logic [31:0]        step_q;
    logic [27:0]        warp_q;
    logic [16:0]        shape_q;
    logic signed [19:0] gain_q;

    // oscillator and filter state
    longint phase_q;
    longint filt_q;
    longint prev_noise_q;

    logic signed [23:0] lfo_expected[$];

    assign pending = lfo_expected.size();

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [23:0] lfo_next(input logic signed [23:0] noise);
        longint n, stp, p, k, y, s, a, den, num, f, m, o;
        n   = longint'(noise);
        stp = longint'((longint'(step_q) * longint'(rate_q)) >>> 20);
        p   = phase_q + stp;
        if (p > longint'(lsnb_pkg::PI_Q))
        begin
            k = (p - longint'(lsnb_pkg::PI_Q) + longint'(lsnb_pkg::TWO_PI_Q) - 1)
                / longint'(lsnb_pkg::TWO_PI_Q);
            p = p - k * longint'(lsnb_pkg::TWO_PI_Q);
        end
        phase_q = p;
        y = ((longint'(lsnb_pkg::K1_Q) * p) >>> 30)
          - ((longint'(lsnb_pkg::K2_Q) * ((p * mag(p)) >>> 28)) >>> 30);
        s = ((longint'(lsnb_pkg::K3_Q) * (((y * mag(y)) >>> 28) - y)) >>> 30) + y;
        a   = (longint'(rate_q) * longint'(lsnb_pkg::TWO_PI_Q)) >>> 36;
        den = longint'(warp_q) + a;
        if (den == 0)
            f = filt_q;
        else
        begin
            num = a * (prev_noise_q + n - filt_q) + longint'(warp_q) * filt_q;
            f = num / den;
            if (f > 64'sd2147483647)
                f = 64'sd2147483647;
            else if (f < -64'sd2147483648)
                f = -64'sd2147483648;
        end
        filt_q       = f;
        prev_noise_q = n;
        m = (((s - f * 256) * longint'(shape_q)) >>> 16) + f * 256;
        o = (m * longint'(gain_q)) >>> 24;
        if (o > 64'sd8388607)
            o = 64'sd8388607;
        else if (o < -64'sd8388608)
            o = -64'sd8388608;
        return o[23:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_q       <= '0;
            step_q       <= '0;
            warp_q       <= lsnb_pkg::WARP_RESET;
            shape_q      <= '0;
            gain_q       <= '0;
            phase_q      = 0;
            filt_q       = 0;
            prev_noise_q = 0;
            fail_count   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (lsnb_pkg::cfg_reg_t'(cfg_index))
                    lsnb_pkg::REG_RATE:  rate_q  <= cfg_data[23:0];
                    lsnb_pkg::REG_STEP:  step_q  <= cfg_data;
                    lsnb_pkg::REG_WARP:  warp_q  <= cfg_data[27:0];
                    lsnb_pkg::REG_SHAPE: shape_q <= cfg_data[16:0];
                    lsnb_pkg::REG_GAIN:  gain_q  <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (operation == lsnb_pkg::OPN_RESTART)
                begin
                    phase_q      = 0;
                    filt_q       = 0;
                    prev_noise_q = 0;
                end
                else
                    lfo_expected.push_back(lfo_next(noise_sample));
            end
            if (out_valid && !out_stall)
            begin
                if (lfo_expected.size() == 0)
                begin
                    $error("lfo_value: unexpected item, actual %0d", lfo_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    logic signed [23:0] want;
                    want = lfo_expected.pop_front();
                    if (lfo_value !== want)
                    begin
                        $error("lfo_value: expected %0d, actual %0d", want, lfo_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/lfo_sine_noise_blend_core_tb.sv */
// lfo_sine_noise_blend_core_tb: clock, reset, configuration phases and item
// stimulus for the LFO blend core. Depends on lsnb_pkg, lsnb_tb_checker and the RTL.
`timescale 1ns / 100ps
module lfo_sine_noise_blend_core_tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               operation;
    logic signed [23:0] noise_sample;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] lfo_value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    logic calm_window;   // no idling on either side
    int   hold_off;      // receiver hold-off request, in cycles

    lfo_sine_noise_blend_core dut (.*);

    lsnb_tb_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stall, calm stretch, and one long hold-off on request
    always @(negedge clk or negedge rst_n)
    begin
        int hold_left;
        bit hold_used;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            hold_used = 1'b0;
        end
        else
        begin
            if (hold_off > 0 && !hold_used)
            begin
                hold_left = hold_off;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (calm_window)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 32);
        end
    end

    task automatic write_reg(input lsnb_pkg::cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop the input, wait for all results, then keep waiting with the input idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_item(input logic op, input logic [23:0] noise);
        @(negedge clk);
        while (!calm_window && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        noise_sample <= noise;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic set_all(input logic [23:0] rate, input logic [31:0] stp,
                           input logic [27:0] warp, input logic [16:0] shape,
                           input logic [19:0] gain);
        settle();
        write_reg(lsnb_pkg::REG_RATE, {8'd0, rate});
        write_reg(lsnb_pkg::REG_STEP, stp);
        write_reg(lsnb_pkg::REG_WARP, {4'd0, warp});
        write_reg(lsnb_pkg::REG_SHAPE, {15'd0, shape});
        write_reg(lsnb_pkg::REG_GAIN, {{12{gain[19]}}, gain});
    endtask

    function automatic logic [23:0] rand_noise();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(2047)) - 24'd1024;
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        int phase_idx;
        logic [23:0] rate;
        logic [27:0] warp;
        in_valid     = 1'b0;
        operation    = lsnb_pkg::OPN_TICK;
        noise_sample = '0;
        cfg_valid    = 1'b0;
        cfg_index    = lsnb_pkg::REG_RATE;
        cfg_data     = '0;
        calm_window  = 1'b0;
        hold_off     = 0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults: gain zero, so every value is zero
        send_item(lsnb_pkg::OPN_TICK, 24'h7FFFFF);
        send_item(lsnb_pkg::OPN_TICK, 24'h800000);

        // slow sine only, full gain
        set_all(24'h010000, 32'd17000000, 28'd384000, 17'd65536, 20'h7FFFF);
        repeat (4) send_item(lsnb_pkg::OPN_TICK, 24'h000000);
        send_item(lsnb_pkg::OPN_RESTART, 24'h7FFFFF);
        send_item(lsnb_pkg::OPN_TICK, 24'h123456);

        // huge step: several two-pi wraps per tick
        set_all(24'hFFFFFF, 32'hFFFFFFFF, 28'd1, 17'd65536, 20'h7FFFF);
        repeat (3) send_item(lsnb_pkg::OPN_TICK, 24'h7FFFFF);

        // all noise, extreme gains and noise: output saturation
        set_all(24'hFFFFFF, 32'd0, 28'd1, 17'd0, 20'h7FFFF);
        send_item(lsnb_pkg::OPN_TICK, 24'h7FFFFF);
        send_item(lsnb_pkg::OPN_TICK, 24'h7FFFFF);
        send_item(lsnb_pkg::OPN_TICK, 24'h800000);
        set_all(24'd0, 32'd0, 28'hFFFFFFF, 17'd32768, 20'h80000);
        send_item(lsnb_pkg::OPN_TICK, 24'h800000);
        send_item(lsnb_pkg::OPN_TICK, 24'h7FFFFF);
        send_item(lsnb_pkg::OPN_RESTART, 24'h000000);
        send_item(lsnb_pkg::OPN_TICK, 24'h000001);

        // random phases; one long calm stretch and one long receiver hold-off
        for (phase_idx = 0; phase_idx < 6; phase_idx++)
        begin
            rate = (phase_idx == 5) ? 24'hFFFFFF : 24'($urandom_range(2000000));
            warp = (phase_idx == 4) ? 28'd1
                 : (phase_idx == 5) ? 28'hFFFFFFF : 28'($urandom_range(1000000, 1));
            set_all(rate, $urandom_range(40000000),
                    warp, 17'($urandom_range(65536)), 20'($urandom));
            calm_window = (phase_idx == 2);
            if (phase_idx == 3)
                hold_off = 600;
            repeat (245)
                send_item(($urandom_range(99) < 5) ? lsnb_pkg::OPN_RESTART
                                                   : lsnb_pkg::OPN_TICK, rand_noise());
            hold_off = 0;
            calm_window = 1'b0;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        settle();
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
